// File: sv/arpc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the ARP responder with address cache.
package arpc_pkg;

    localparam int unsigned CACHE_DEPTH_DEF = 128;

    localparam int unsigned IP_W    = 32;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned ENTRY_W = IP_W + MAC_W;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 64;

    localparam logic [PADDR_W-1:0] REG_OWN_IP  = 4'h0;
    localparam logic [PADDR_W-1:0] REG_OWN_MAC = 4'h8;

    localparam logic ACT_MESSAGE = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    localparam logic [15:0] ARP_MIN_LEN = 16'd28;
    localparam logic [15:0] HTYPE_ETHER = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HLEN_ETHER  = 8'd6;
    localparam logic [7:0]  PLEN_IPV4   = 8'd4;
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    localparam logic [IP_W-1:0]  IP_BCAST = {IP_W{1'b1}};
    localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_REQUEST = 2'd2
    } send_kind_t;

    typedef struct packed {
        logic [IP_W-1:0]  own_ip;
        logic [MAC_W-1:0] own_mac;
    } cfg_t;

endpackage

// File: sv/arpc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface arpc_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] frame_length;
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] lookup_ip;

    modport source (
        output valid, action, frame_length, hardware_type, protocol_type, hw_addr_len,
               proto_addr_len, arp_opcode, sender_mac, sender_ip, target_ip, lookup_ip,
        input  ready
    );
    modport sink (
        input  valid, action, frame_length, hardware_type, protocol_type, hw_addr_len,
               proto_addr_len, arp_opcode, sender_mac, sender_ip, target_ip, lookup_ip,
        output ready
    );
endinterface

interface arpc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [47:0] send_dest_mac;
    logic [31:0] send_dest_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;

    modport source (
        output valid, send_kind, send_dest_mac, send_dest_ip, lookup_hit, lookup_mac,
        input  ready
    );
    modport sink (
        input  valid, send_kind, send_dest_mac, send_dest_ip, lookup_hit, lookup_mac,
        output ready
    );
endinterface

// File: sv/arpc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 2,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/arpc_cfg.sv
`timescale 1ns / 1ps
// APB register block holding the station's own IP and MAC addresses.
module arpc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arpc_pkg::PADDR_W-1:0] paddr,
    input  logic [arpc_pkg::PDATA_W-1:0] pwdata,
    output logic [arpc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output arpc_pkg::cfg_t               cfg
);

    logic [arpc_pkg::IP_W-1:0]  own_ip_reg;
    logic [arpc_pkg::MAC_W-1:0] own_mac_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr == arpc_pkg::REG_OWN_IP)
            begin
                own_ip_reg <= pwdata[arpc_pkg::IP_W-1:0];
            end
            if (paddr == arpc_pkg::REG_OWN_MAC)
            begin
                own_mac_reg <= pwdata[arpc_pkg::MAC_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == arpc_pkg::REG_OWN_IP)
        begin
            prdata = arpc_pkg::PDATA_W'(own_ip_reg);
        end
        else if (paddr == arpc_pkg::REG_OWN_MAC)
        begin
            prdata = arpc_pkg::PDATA_W'(own_mac_reg);
        end
    end

    assign cfg.own_ip  = own_ip_reg;
    assign cfg.own_mac = own_mac_reg;

endmodule

// File: sv/arpc_engine.sv
`timescale 1ns / 1ps
// Sequencer that checks messages, fills the ring cache and walks it with one comparator.
module arpc_engine #(
    parameter  int unsigned CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF,
    localparam int unsigned AW          = $clog2(CACHE_DEPTH),
    localparam int unsigned CW          = $clog2(CACHE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  arpc_pkg::cfg_t               cfg,
    arpc_req_if.sink                     req,
    arpc_rsp_if.source                   rsp,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [arpc_pkg::ENTRY_W-1:0] ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [arpc_pkg::ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [CW-1:0] COUNT_FULL = CW'(CACHE_DEPTH);
    localparam logic [AW-1:0] PTR_LAST   = AW'(CACHE_DEPTH - 1);

    state_t                     state_reg, state_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic                       last_reg, last_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [arpc_pkg::IP_W-1:0]  lip_reg, lip_next;

    arpc_pkg::send_kind_t       kind_reg, kind_next;
    logic [arpc_pkg::MAC_W-1:0] dmac_reg, dmac_next;
    logic [arpc_pkg::IP_W-1:0]  dip_reg, dip_next;
    logic                       hit_reg, hit_next;
    logic [arpc_pkg::MAC_W-1:0] lmac_reg, lmac_next;

    logic accept;
    logic msg_ok;
    logic store;
    logic issue;
    logic match;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign msg_ok = (req.frame_length >= arpc_pkg::ARP_MIN_LEN)
                 && (req.hardware_type == arpc_pkg::HTYPE_ETHER)
                 && (req.protocol_type == arpc_pkg::PTYPE_IPV4)
                 && (req.hw_addr_len == arpc_pkg::HLEN_ETHER)
                 && (req.proto_addr_len == arpc_pkg::PLEN_IPV4)
                 && (req.target_ip == cfg.own_ip);

    assign store = accept && (req.action == arpc_pkg::ACT_MESSAGE) && msg_ok
                && (req.arp_opcode == arpc_pkg::OPC_REPLY);

    // Entries below the fill count are exactly the valid ones, since the ring fills from zero.
    assign issue = (state_reg == ST_SCAN) && (idx_reg < count_reg);
    assign match = pend_reg
                && (ram_rdata[arpc_pkg::ENTRY_W-1 -: arpc_pkg::IP_W] == lip_reg);

    assign ram_we    = store;
    assign ram_waddr = ptr_reg;
    assign ram_wdata = {req.sender_ip, req.sender_mac};
    assign ram_re    = issue;
    assign ram_raddr = idx_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        last_next  = last_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        lip_next   = lip_reg;
        kind_next  = kind_reg;
        dmac_next  = dmac_reg;
        dip_next   = dip_reg;
        hit_next   = hit_reg;
        lmac_next  = lmac_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = arpc_pkg::KIND_NONE;
                    dmac_next  = '0;
                    dip_next   = '0;
                    hit_next   = 1'b0;
                    lmac_next  = '0;
                    state_next = ST_DONE;
                    if (req.action == arpc_pkg::ACT_MESSAGE)
                    begin
                        if (msg_ok && (req.arp_opcode == arpc_pkg::OPC_REQUEST))
                        begin
                            kind_next = arpc_pkg::KIND_REPLY;
                            dmac_next = req.sender_mac;
                            dip_next  = req.sender_ip;
                        end
                        if (store)
                        begin
                            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + AW'(1);
                            if (count_reg != COUNT_FULL)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    else if ((req.lookup_ip == arpc_pkg::IP_BCAST) || (cfg.own_ip == '0))
                    begin
                        lmac_next = arpc_pkg::MAC_ONES;
                    end
                    else if (count_reg == '0)
                    begin
                        kind_next = arpc_pkg::KIND_REQUEST;
                        dmac_next = arpc_pkg::MAC_ONES;
                        dip_next  = req.lookup_ip;
                        lmac_next = arpc_pkg::MAC_ONES;
                    end
                    else
                    begin
                        lip_next   = req.lookup_ip;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        last_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Read entry idx while comparing the entry read in the previous cycle.
                pend_next = issue;
                last_next = (idx_reg == count_reg - CW'(1));
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (match)
                begin
                    hit_next   = 1'b1;
                    lmac_next  = ram_rdata[arpc_pkg::MAC_W-1:0];
                    state_next = ST_DONE;
                end
                else if (pend_reg && last_reg)
                begin
                    kind_next  = arpc_pkg::KIND_REQUEST;
                    dmac_next  = arpc_pkg::MAC_ONES;
                    dip_next   = lip_reg;
                    lmac_next  = arpc_pkg::MAC_ONES;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lip_reg  <= lip_next;
        kind_reg <= kind_next;
        dmac_reg <= dmac_next;
        dip_reg  <= dip_next;
        hit_reg  <= hit_next;
        lmac_reg <= lmac_next;
    end

    assign rsp.valid         = (state_reg == ST_DONE);
    assign rsp.send_kind     = kind_reg;
    assign rsp.send_dest_mac = dmac_reg;
    assign rsp.send_dest_ip  = dip_reg;
    assign rsp.lookup_hit    = hit_reg;
    assign rsp.lookup_mac    = lmac_reg;

endmodule

// File: sv/arp_responder_with_cache_core.sv
`timescale 1ns / 1ps
// ARP responder for IPv4 over Ethernet with a ring cache of resolved addresses.
//
// Items enter on req (valid/ready) and leave on rsp (valid/ready), one result word
// per item. own_ip (byte address 0) and own_mac (byte address 8) are to be written
// over the APB port only while the block is idle; the block itself does not enforce
// this, and pready is always high. A received ARP message needs no cache walk: a
// valid request for own_ip yields a reply word, a valid reply is stored at the ring
// insert position. A resolve walks the filled cache entries from index 0 through
// one RAM read port and one 32-bit comparator, one entry per cycle, with the read
// pipelined ahead of the compare. The walk stops at the first match, so the lowest
// matching entry wins; a miss yields a broadcast request word. A broadcast lookup
// address or a zero own_ip skips the walk and answers with an all-ones lookup_mac.
// One item is in flight at a time: req.ready is low from acceptance until the result
// word has been taken. While rsp.ready is low the result is held unchanged.
// Reset empties the cache (fill count and insert pointer to zero) and clears both
// address registers; no clearing pass is needed, the block is ready right after reset.
module arp_responder_with_cache_core #(
    parameter int unsigned CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arpc_pkg::PADDR_W-1:0] paddr,
    input  logic [arpc_pkg::PDATA_W-1:0] pwdata,
    output logic [arpc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    arpc_req_if.sink                     req,
    arpc_rsp_if.source                   rsp
);

    localparam int unsigned AW = $clog2(CACHE_DEPTH);

    arpc_pkg::cfg_t               cfg;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [arpc_pkg::ENTRY_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [arpc_pkg::ENTRY_W-1:0] ram_rdata;

    arpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (CACHE_DEPTH)
    ) u_cache (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arpc_engine #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

// File: sv/arpc_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the ARP responder, bound to the top level.
module arpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  send_kind,
    input logic [47:0] send_dest_mac,
    input logic [31:0] send_dest_ip,
    input logic        lookup_hit,
    input logic [47:0] lookup_mac
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(send_kind)
            && $stable(send_dest_mac) && $stable(send_dest_ip)
            && $stable(lookup_hit) && $stable(lookup_mac))
        else $error("result word changed while stalled");

    // Only one item in flight: no intake while a result waits, never two intakes in a row.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid) && !(in_valid && in_ready && $past(in_valid && in_ready)))
        else $error("input ready while a result is pending");

    a_reply_no_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_kind == arpc_pkg::KIND_REPLY |-> !lookup_hit && lookup_mac == '0)
        else $error("ARP reply carries lookup data");

    a_hit_sends_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lookup_hit |-> send_kind == arpc_pkg::KIND_NONE)
        else $error("cache hit also requests a send");

    a_miss_broadcast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_kind == arpc_pkg::KIND_REQUEST
            |-> send_dest_mac == arpc_pkg::MAC_ONES && lookup_mac == arpc_pkg::MAC_ONES
                && !lookup_hit)
        else $error("broadcast request with bad addresses");

endmodule

bind arp_responder_with_cache_core arpc_checker u_arpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .send_kind     (rsp.send_kind),
    .send_dest_mac (rsp.send_dest_mac),
    .send_dest_ip  (rsp.send_dest_ip),
    .lookup_hit    (rsp.lookup_hit),
    .lookup_mac    (rsp.lookup_mac)
);

// File: tb/arp_responder_with_cache_core_test.sv
`timescale 1ns / 1ps
// Randomized self-checking bench for the ARP responder with cache, scoreboard class included.
import arpc_pkg::*;

typedef struct {
    logic        action;
    logic [15:0] frame_length;
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] lookup_ip;
} arp_item_t;

typedef struct {
    send_kind_t  kind;
    logic [47:0] dest_mac;
    logic [31:0] dest_ip;
    logic        hit;
    logic [47:0] lookup_mac;
} arp_answer_t;

class arp_scoreboard;
    localparam int DEPTH = CACHE_DEPTH_DEF;

    logic [IP_W-1:0]  own_ip;
    logic [MAC_W-1:0] own_mac;
    logic [IP_W-1:0]  cache_ip [DEPTH];
    logic [MAC_W-1:0] cache_mac [DEPTH];
    bit               cache_valid [DEPTH];
    logic [6:0]       insert_ptr;
    arp_answer_t      pending_answers [$];
    int               mismatches;

    function new();
        own_ip = '0;
        own_mac = '0;
        insert_ptr = '0;
        mismatches = 0;
        foreach (cache_valid[i])
        begin
            cache_valid[i] = 1'b0;
        end
    endfunction

    function void set_config(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        own_ip = ip;
        own_mac = mac;
    endfunction

    function int pending();
        return pending_answers.size();
    endfunction

    // Work out the answer to one accepted word and update the cache copy.
    function void absorb_item(arp_item_t it);
        arp_answer_t ans;
        bit accepted;
        ans.kind = KIND_NONE;
        ans.dest_mac = '0;
        ans.dest_ip = '0;
        ans.hit = 1'b0;
        ans.lookup_mac = '0;
        if (it.action == ACT_MESSAGE)
        begin
            accepted = it.frame_length >= ARP_MIN_LEN && it.hardware_type == HTYPE_ETHER &&
                       it.protocol_type == PTYPE_IPV4 && it.hw_addr_len == HLEN_ETHER &&
                       it.proto_addr_len == PLEN_IPV4 && it.target_ip == own_ip;
            if (accepted && it.arp_opcode == OPC_REQUEST)
            begin
                ans.kind = KIND_REPLY;
                ans.dest_mac = it.sender_mac;
                ans.dest_ip = it.sender_ip;
            end
            else if (accepted && it.arp_opcode == OPC_REPLY)
            begin
                cache_ip[insert_ptr] = it.sender_ip;
                cache_mac[insert_ptr] = it.sender_mac;
                cache_valid[insert_ptr] = 1'b1;
                insert_ptr = insert_ptr + 7'd1;
            end
        end
        else if (it.lookup_ip == IP_BCAST || own_ip == '0)
        begin
            ans.lookup_mac = MAC_ONES;
        end
        else
        begin
            ans.kind = KIND_REQUEST;
            ans.dest_mac = MAC_ONES;
            ans.dest_ip = it.lookup_ip;
            ans.lookup_mac = MAC_ONES;
            // walk downward so the lowest matching entry wins
            for (int i = DEPTH - 1; i >= 0; i--)
            begin
                if (cache_valid[i] && cache_ip[i] == it.lookup_ip)
                begin
                    ans.kind = KIND_NONE;
                    ans.dest_mac = '0;
                    ans.dest_ip = '0;
                    ans.hit = 1'b1;
                    ans.lookup_mac = cache_mac[i];
                end
            end
        end
        pending_answers.push_back(ans);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    function void check_answer(arp_answer_t got);
        arp_answer_t want;
        if (pending_answers.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result word expected none actual kind %0d mac %h",
                     $time, got.kind, got.lookup_mac);
            return;
        end
        want = pending_answers.pop_front();
        compare_field("send_kind", 64'(want.kind), 64'(got.kind));
        compare_field("send_dest_mac", 64'(want.dest_mac), 64'(got.dest_mac));
        compare_field("send_dest_ip", 64'(want.dest_ip), 64'(got.dest_ip));
        compare_field("lookup_hit", 64'(want.hit), 64'(got.hit));
        compare_field("lookup_mac", 64'(want.lookup_mac), 64'(got.lookup_mac));
    endfunction
endclass

module arp_responder_with_cache_core_test;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    arpc_req_if req_ch ();
    arpc_rsp_if rsp_ch ();

    arp_scoreboard sb = new();

    bit          idling = 1'b1;
    bit          hold_off_req = 1'b0;
    logic [31:0] cur_ip = '0;
    logic [31:0] ip_pool [16];

    arp_responder_with_cache_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        #12_000_000;
        $display("arp_responder_with_cache_core verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req <= 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 99) < 12)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        arp_answer_t got;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.kind = send_kind_t'(rsp_ch.send_kind);
            got.dest_mac = rsp_ch.send_dest_mac;
            got.dest_ip = rsp_ch.send_dest_ip;
            got.hit = rsp_ch.lookup_hit;
            got.lookup_mac = rsp_ch.lookup_mac;
            sb.check_answer(got);
        end
    end

    function automatic arp_item_t noise_item();
        arp_item_t it;
        it.action = 1'($urandom);
        it.frame_length = 16'($urandom);
        it.hardware_type = 16'($urandom);
        it.protocol_type = 16'($urandom);
        it.hw_addr_len = 8'($urandom);
        it.proto_addr_len = 8'($urandom);
        it.arp_opcode = 16'($urandom);
        it.sender_mac = 48'({$urandom, $urandom});
        it.sender_ip = $urandom;
        it.target_ip = $urandom;
        it.lookup_ip = $urandom;
        return it;
    endfunction

    function automatic arp_item_t well_formed(logic [15:0] opc, logic [31:0] sip,
                                              logic [47:0] smac, logic [31:0] tip);
        arp_item_t it;
        it = noise_item();
        it.action = ACT_MESSAGE;
        if ($urandom_range(0, 9) == 0)
            it.frame_length = 16'($urandom_range(ARP_MIN_LEN, 65535));
        else
            it.frame_length = 16'($urandom_range(ARP_MIN_LEN, 64));
        it.hardware_type = HTYPE_ETHER;
        it.protocol_type = PTYPE_IPV4;
        it.hw_addr_len = HLEN_ETHER;
        it.proto_addr_len = PLEN_IPV4;
        it.arp_opcode = opc;
        it.sender_ip = sip;
        it.sender_mac = smac;
        it.target_ip = tip;
        return it;
    endfunction

    function automatic arp_item_t resolve_item(logic [31:0] ip);
        arp_item_t it;
        it = noise_item();
        it.action = ACT_RESOLVE;
        it.lookup_ip = ip;
        return it;
    endfunction

    // Break exactly one acceptance check of a well-formed message.
    function automatic arp_item_t break_one(arp_item_t it, int which);
        case (which)
            0: it.frame_length = 16'($urandom_range(0, ARP_MIN_LEN - 1));
            1: it.hardware_type = HTYPE_ETHER ^ 16'($urandom_range(1, 16'hFFFF));
            2: it.protocol_type = PTYPE_IPV4 ^ 16'($urandom_range(1, 16'hFFFF));
            3: it.hw_addr_len = HLEN_ETHER ^ 8'($urandom_range(1, 8'hFF));
            4: it.proto_addr_len = PLEN_IPV4 ^ 8'($urandom_range(1, 8'hFF));
            5: it.target_ip = it.target_ip ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
            default: it.arp_opcode = 16'($urandom_range(OPC_REPLY + 1, 16'hFFFF));
        endcase
        return it;
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t it;
        int pick;
        logic [15:0] opc;
        pick = $urandom_range(0, 99);
        opc = (pick < 35) ? OPC_REPLY : OPC_REQUEST;
        it = well_formed(opc, ip_pool[$urandom_range(0, 15)], 48'({$urandom, $urandom}),
                         cur_ip);
        if (pick < 55)
        begin
            if ($urandom_range(0, 3) == 0)
                it.sender_ip = $urandom;
        end
        else if (pick < 85)
        begin
            if ($urandom_range(0, 9) < 6)
                it = resolve_item(ip_pool[$urandom_range(0, 15)]);
            else if ($urandom_range(0, 3) != 0)
                it = resolve_item($urandom);
            else
                it = resolve_item(IP_BCAST);
        end
        else if (pick < 93)
        begin
            it = break_one(it, $urandom_range(0, 6));
        end
        else
        begin
            it = noise_item();
        end
        return it;
    endfunction

    task automatic send_item(input arp_item_t it);
        if (idling && $urandom_range(0, 99) < 15)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= it.action;
        req_ch.frame_length <= it.frame_length;
        req_ch.hardware_type <= it.hardware_type;
        req_ch.protocol_type <= it.protocol_type;
        req_ch.hw_addr_len <= it.hw_addr_len;
        req_ch.proto_addr_len <= it.proto_addr_len;
        req_ch.arp_opcode <= it.arp_opcode;
        req_ch.sender_mac <= it.sender_mac;
        req_ch.sender_ip <= it.sender_ip;
        req_ch.target_ip <= it.target_ip;
        req_ch.lookup_ip <= it.lookup_ip;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.absorb_item(it);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leave the bus selected after the access; the caller releases it.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
    endtask

    task automatic configure(input logic [31:0] ip, input logic [47:0] mac);
        drain();
        write_reg(REG_OWN_IP, 64'(ip));
        write_reg(REG_OWN_MAC, 64'(mac));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_config(ip, mac);
        cur_ip = ip;
        for (int i = 0; i < 16; i++)
            ip_pool[i] = $urandom;
        ip_pool[0] = '0;
        ip_pool[1] = ip;
        ip_pool[2] = ip + 32'd1;
    endtask

    initial
    begin
        arp_item_t it;
        logic [31:0] phase_ip [5];
        logic [47:0] phase_mac [5];

        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.action <= ACT_MESSAGE;
        req_ch.frame_length <= '0;
        req_ch.hardware_type <= '0;
        req_ch.protocol_type <= '0;
        req_ch.hw_addr_len <= '0;
        req_ch.proto_addr_len <= '0;
        req_ch.arp_opcode <= '0;
        req_ch.sender_mac <= '0;
        req_ch.sender_ip <= '0;
        req_ch.target_ip <= '0;
        req_ch.lookup_ip <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unconfigured station: resolves refused, target 0 still matches.
        send_item(resolve_item(32'h0A00_0001));
        send_item(resolve_item(IP_BCAST));
        send_item(well_formed(OPC_REQUEST, 32'h0A00_0002, 48'h0200_0000_0002, 32'h0));
        send_item(well_formed(OPC_REPLY, 32'hC0A8_0005, 48'h0200_0000_0005, 32'h0));

        configure(32'hC0A8_0001, 48'h0200_5E10_0001);
        send_item(resolve_item(32'hC0A8_0005));
        send_item(well_formed(OPC_REQUEST, IP_BCAST, MAC_ONES, cur_ip));
        send_item(well_formed(OPC_REPLY, 32'h0, 48'h0, cur_ip));
        send_item(resolve_item(32'h0));
        // duplicate address: the older, lower entry must still win
        send_item(well_formed(OPC_REPLY, 32'hC0A8_0005, 48'h0200_0000_0055, cur_ip));
        send_item(resolve_item(32'hC0A8_0005));
        send_item(resolve_item(32'h0808_0808));
        send_item(resolve_item(IP_BCAST));
        for (int k = 0; k < 10; k++)
        begin
            it = well_formed(OPC_REQUEST, 32'hC0A8_00F0 + k, 48'h0200_0000_00F0 + k, cur_ip);
            it.frame_length = ARP_MIN_LEN + 16'd32;
            case (k)
                0: it.frame_length = ARP_MIN_LEN - 16'd1;
                1: it.frame_length = 16'h0000;
                2: it.frame_length = 16'hFFFF;
                3: it.hardware_type = 16'h0000;
                4: it.protocol_type = 16'h0008;
                5: it.hw_addr_len = 8'h00;
                6: it.proto_addr_len = 8'hFF;
                7: it.target_ip = cur_ip ^ 32'h1;
                8: it.arp_opcode = 16'h0000;
                default: it.arp_opcode = 16'hFFFF;
            endcase
            send_item(it);
        end
        it = well_formed(OPC_REPLY, IP_BCAST, MAC_ONES, cur_ip);
        it.frame_length = ARP_MIN_LEN;
        send_item(it);
        it = well_formed(OPC_REPLY, 32'h0B0B_0B0B, 48'h0200_0000_0B0B, cur_ip);
        it.hardware_type = 16'h0100;
        send_item(it);
        send_item(resolve_item(32'h0B0B_0B0B));

        phase_ip[0] = 32'hC0A8_0001;
        phase_mac[0] = 48'h0200_5E10_0001;
        phase_ip[1] = 32'hFFFF_FFFF;
        phase_mac[1] = MAC_ONES;
        phase_ip[2] = 32'h0000_0001;
        phase_mac[2] = 48'h0;
        phase_ip[3] = 32'h0;
        phase_mac[3] = 48'({$urandom, $urandom});
        phase_ip[4] = $urandom;
        phase_mac[4] = 48'({$urandom, $urandom});

        for (int ph = 0; ph < 5; ph++)
        begin
            configure(phase_ip[ph], phase_mac[ph]);
            for (int n = 0; n < 335; n++)
            begin
                if (ph == 0 && n == 60)
                    hold_off_req <= 1'b1;
                if (ph == 4 && n == 60)
                    idling = 1'b0;
                send_item(random_item());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("arp_responder_with_cache_core verification clean");
        else
            $display("arp_responder_with_cache_core verification failed");
        $finish;
    end

endmodule
